>>> rtl/alfe_pkg.sv
// Package for the addressable LED frame encoder.
// Holds shared constants, operation codes and the command/result records.
// No dependencies.
package alfe_pkg;

   // Default geometry of the pixel store and frame preamble
   localparam int NUM_LIGHTS_DEFAULT     = 2;
   localparam int LEDS_PER_LIGHT_DEFAULT = 8;
   localparam int RESET_BYTES_DEFAULT    = 60;

   // Pixel coding on the SPI line
   localparam int             BITS_PER_PIXEL = 24;
   localparam logic [4:0]     BIT_TOP        = 5'd23;
   localparam logic [7:0]     CODE_ZERO      = 8'h06;
   localparam logic [7:0]     CODE_ONE       = 8'h1E;
   localparam logic [7:0]     CODE_RESET     = 8'h00;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Classified command; pixel_idx is only meaningful for OP_WRITE
   typedef struct packed {
      op_type      kind;
      logic [15:0] pixel_idx;
      logic [23:0] color;      // green, red, blue from the top bits down
   } cmd_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] code_byte;
      logic       frame_last;
      logic       busy_res;
   } rsp_type;

endpackage

>>> rtl/alfe_front.sv
// Front end of the LED frame encoder: decodes an input transfer into a command.
// Depends on alfe_pkg.
module alfe_front #(
   parameter int NUM_LIGHTS     = alfe_pkg::NUM_LIGHTS_DEFAULT,
   parameter int LEDS_PER_LIGHT = alfe_pkg::LEDS_PER_LIGHT_DEFAULT
) (
   input  logic [1:0]       operation,
   input  logic [7:0]       red,
   input  logic [7:0]       green,
   input  logic [7:0]       blue,
   input  logic [7:0]       light_index,
   input  logic [7:0]       led_index,
   output alfe_pkg::cmd_type cmd
);

   logic in_range;

   always_comb begin
      in_range = (light_index < 8'(NUM_LIGHTS)) && (led_index < 8'(LEDS_PER_LIGHT));

      cmd.color     = {green, red, blue};
      cmd.pixel_idx = 16'({8'b0, light_index} * 16'(LEDS_PER_LIGHT)) + {8'b0, led_index};

      case (operation)
         alfe_pkg::OP_WRITE: begin
            // out-of-range write behaves exactly like a no-op
            cmd.kind = in_range ? alfe_pkg::OP_WRITE : alfe_pkg::OP_NOP;
         end
         alfe_pkg::OP_START: begin
            cmd.kind = alfe_pkg::OP_START;
         end
         alfe_pkg::OP_TICK: begin
            cmd.kind = alfe_pkg::OP_TICK;
         end
         default: begin
            cmd.kind = alfe_pkg::OP_NOP;
         end
      endcase
   end

endmodule

>>> rtl/alfe_queue.sv
// Two-entry command queue between the front end and the frame engine.
// Depends on alfe_pkg.
module alfe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  alfe_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output alfe_pkg::cmd_type pop_cmd
);

   localparam int PW = (alfe_pkg::QUEUE_DEPTH > 1) ? $clog2(alfe_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(alfe_pkg::QUEUE_DEPTH + 1);

   alfe_pkg::cmd_type entry_ff [alfe_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] ptr);
      logic [PW-1:0] nxt;
      nxt = (ptr == PW'(alfe_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
      return nxt;
   endfunction

   assign full    = (count_ff == CW'(alfe_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/alfe_back.sv
// Frame engine of the LED frame encoder: pixel store, frame counters, result register.
// Depends on alfe_pkg.
module alfe_back #(
   parameter int NUM_LIGHTS     = alfe_pkg::NUM_LIGHTS_DEFAULT,
   parameter int LEDS_PER_LIGHT = alfe_pkg::LEDS_PER_LIGHT_DEFAULT,
   parameter int RESET_BYTES    = alfe_pkg::RESET_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  alfe_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output alfe_pkg::rsp_type rsp
);

   localparam int PIXEL_COUNT = NUM_LIGHTS * LEDS_PER_LIGHT;
   localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int RW = (RESET_BYTES > 1) ? $clog2(RESET_BYTES) : 1;

   typedef enum logic [1:0] {
      ST_FETCH = 2'b01,
      ST_EXEC  = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   alfe_pkg::cmd_type cmd_ff, cmd_in;
   logic              sending_ff, sending_in;
   logic              init_ff, init_in;          // power-up frame: store not yet cleared
   logic              preamble_ff, preamble_in;  // sending the zero bytes
   logic [RW-1:0]     pre_cnt_ff, pre_cnt_in;
   logic [AW-1:0]     pix_ff, pix_in;
   logic [4:0]        bit_ff, bit_in;
   logic              out_valid_ff, out_valid_in;
   alfe_pkg::rsp_type out_ff, out_in;

   logic [23:0]       pixel_mem [PIXEL_COUNT];
   logic [23:0]       rd_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   logic [23:0]       mem_wdata;
   logic              out_free;
   alfe_pkg::rsp_type res;

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sending_in   = sending_ff;
      init_in      = init_ff;
      preamble_in  = preamble_ff;
      pre_cnt_in   = pre_cnt_ff;
      pix_in       = pix_ff;
      bit_in       = bit_ff;
      out_free     = !out_valid_ff || rsp_ready;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = pix_ff;
      mem_wdata    = '0;
      res          = '0;

      case (state_ff)
         ST_FETCH: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               res.busy_res = sending_ff;
               case (cmd_ff.kind)
                  alfe_pkg::OP_WRITE: begin
                     if (!sending_ff) begin
                        mem_we    = 1'b1;
                        mem_addr  = cmd_ff.pixel_idx[AW-1:0];
                        mem_wdata = cmd_ff.color;
                     end
                  end
                  alfe_pkg::OP_START: begin
                     sending_in   = 1'b1;
                     res.busy_res = 1'b1;
                  end
                  alfe_pkg::OP_TICK: begin
                     if (sending_ff) begin
                        res.byte_valid = 1'b1;
                        res.busy_res   = 1'b1;
                        if (preamble_ff) begin
                           res.code_byte = alfe_pkg::CODE_RESET;
                           if (pre_cnt_ff == RW'(RESET_BYTES - 1)) begin
                              preamble_in = 1'b0;
                           end else begin
                              pre_cnt_in = pre_cnt_ff + 1'b1;
                           end
                        end else begin
                           res.code_byte = (rd_ff[bit_ff] && !init_ff) ?
                                           alfe_pkg::CODE_ONE : alfe_pkg::CODE_ZERO;
                           if (bit_ff == '0) begin
                              // pixel fully sent: clear it behind the read
                              mem_we    = 1'b1;
                              mem_addr  = pix_ff;
                              mem_wdata = '0;
                              bit_in    = alfe_pkg::BIT_TOP;
                              if (pix_ff == AW'(PIXEL_COUNT - 1)) begin
                                 res.frame_last = 1'b1;
                                 sending_in     = 1'b0;
                                 init_in        = 1'b0;
                                 preamble_in    = 1'b1;
                                 pre_cnt_in     = '0;
                                 pix_in         = '0;
                              end else begin
                                 pix_in = pix_ff + 1'b1;
                              end
                           end else begin
                              bit_in = bit_ff - 1'b1;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               out_valid_in = 1'b1;
               out_in       = res;
               state_in     = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         sending_ff   <= 1'b1;
         init_ff      <= 1'b1;
         preamble_ff  <= 1'b1;
         pre_cnt_ff   <= '0;
         pix_ff       <= '0;
         bit_ff       <= alfe_pkg::BIT_TOP;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sending_ff   <= sending_in;
         init_ff      <= init_in;
         preamble_ff  <= preamble_in;
         pre_cnt_ff   <= pre_cnt_in;
         pix_ff       <= pix_in;
         bit_ff       <= bit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   // Pixel store: one write port, one registered read port at the frame pointer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= pixel_mem[pix_ff];
   end

   a_last_is_byte: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.frame_last |-> out_ff.byte_valid && out_ff.busy_res)
      else $error("frame_last without a frame byte");

   a_idle_rewound: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> preamble_ff && pre_cnt_ff == '0 && pix_ff == '0 &&
                      bit_ff == alfe_pkg::BIT_TOP)
      else $error("frame counters not rewound while idle");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_wdata != '0 |-> !sending_ff)
      else $error("pixel written during a frame");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= alfe_pkg::BIT_TOP)
      else $error("bit index out of range");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result changed");

endmodule

>>> rtl/addressable_led_frame_encoder.sv
// Top level of the addressable LED frame encoder (WS2812-style SPI bit coding).
// Depends on alfe_pkg, alfe_front, alfe_queue and alfe_back.
//
//   channel   direction  ports                           payload
//   req_*     in         tvalid/tready/tdata/tuser       one command per transfer
//   rsp_*     out        tvalid/tready/tdata/tuser/tlast one result per command
//
// Each command is fetched from the queue, then executed against the pixel store
// with its registered read port; the fetch/execute sequencer sets the rate: the
// next fetch follows execution, which waits while a result is stalled.
// Reset clears all control state and starts the power-up frame at once; the store
// reads as black during that frame and is zeroed behind the read, so no sweep runs.
// A stalled result holds in the output register while the two-entry queue keeps
// taking commands; req_tready drops only when that queue is full.
module addressable_led_frame_encoder #(
   parameter int NUM_LIGHTS     = alfe_pkg::NUM_LIGHTS_DEFAULT,
   parameter int LEDS_PER_LIGHT = alfe_pkg::LEDS_PER_LIGHT_DEFAULT,
   parameter int RESET_BYTES    = alfe_pkg::RESET_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // red, green, blue, light_index, led_index
   input  logic [1:0]  req_tuser,   // operation

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // code_byte, busy_res, zero fill
   output logic        rsp_tuser,   // byte_valid
   output logic        rsp_tlast    // frame_last
);

   alfe_pkg::cmd_type front_cmd;
   alfe_pkg::cmd_type queue_cmd;
   alfe_pkg::rsp_type result;
   logic              queue_full;
   logic              queue_empty;
   logic              queue_pop;
   logic              req_xfer;

   // a transfer is taken whenever the queue has a free slot
   assign req_tready = !queue_full;
   assign req_xfer   = req_tvalid && req_tready;

   alfe_front #(
      .NUM_LIGHTS     (NUM_LIGHTS),
      .LEDS_PER_LIGHT (LEDS_PER_LIGHT)
   ) u_front (
      .operation   (req_tuser),
      .red         (req_tdata[7:0]),
      .green       (req_tdata[15:8]),
      .blue        (req_tdata[23:16]),
      .light_index (req_tdata[31:24]),
      .led_index   (req_tdata[39:32]),
      .cmd         (front_cmd)
   );

   alfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_xfer),
      .push_cmd (front_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .pop_cmd  (queue_cmd)
   );

   alfe_back #(
      .NUM_LIGHTS     (NUM_LIGHTS),
      .LEDS_PER_LIGHT (LEDS_PER_LIGHT),
      .RESET_BYTES    (RESET_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (queue_empty),
      .q_cmd     (queue_cmd),
      .q_pop     (queue_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (result)
   );

   // result packing: code byte low, busy flag above it
   assign rsp_tdata = {7'b0, result.busy_res, result.code_byte};
   assign rsp_tuser = result.byte_valid;
   assign rsp_tlast = result.frame_last;

endmodule

>>> verif/addressable_led_frame_encoder_tb.sv
// Self-checking testbench for addressable_led_frame_encoder: LED frame coding on a stream port.
// Uses alfe_pkg for operation codes and the result record. Runs directed and random
// commands with random idle on both channels.
`timescale 1ns / 100ps

module addressable_led_frame_encoder_tb;

   localparam int LIGHTS      = alfe_pkg::NUM_LIGHTS_DEFAULT;
   localparam int LEDS        = alfe_pkg::LEDS_PER_LIGHT_DEFAULT;
   localparam int PREAMBLE    = alfe_pkg::RESET_BYTES_DEFAULT;
   localparam int PIXELS      = LIGHTS * LEDS;
   localparam int FRAME_BYTES = PREAMBLE + PIXELS * alfe_pkg::BITS_PER_PIXEL;
   // random part: two full frames plus their write phases, about 1950 commands in all
   localparam int RANDOM_ITEMS = 600;
   localparam int CYCLE_LIMIT  = 400000;

   // One command waiting to be driven
   typedef struct {
      alfe_pkg::op_type op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] light;
      logic [7:0] led;
      bit         drain_first;   // hold off until all results are back
      bit         calm;          // no idle on either channel for this one
   } led_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // red, green, blue, light_index, led_index
   logic [1:0]  req_tuser  = alfe_pkg::OP_NOP;   // operation

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // code_byte, busy_res, zero fill
   logic        rsp_tuser;          // byte_valid
   logic        rsp_tlast;          // frame_last

   led_cmd_type        cmd_backlog[$];     // commands not yet driven
   alfe_pkg::rsp_type  code_forecast[$];   // predicted results, oldest first

   // Predictor state: its own copy of the pixel store and frame progress
   logic [23:0] pixel_mem [PIXELS];
   bit          frame_active;
   int          frame_pos;

   int  error_count = 0;
   int  cycle_count = 0;
   int  idle_gap    = 0;
   int  stall_left  = 0;
   bit  calm_now    = 1'b0;
   bit  all_done    = 1'b1;          // sampled at the falling edge, stable at rising
   int  random_count;

   addressable_led_frame_encoder #(
      .NUM_LIGHTS     (LIGHTS),
      .LEDS_PER_LIGHT (LEDS),
      .RESET_BYTES    (PREAMBLE)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor: one result per command. Writes and starts only take
   // effect while idle; a tick during a frame emits the next code byte,
   // and the final byte blanks the store and ends the frame.
   // ------------------------------------------------------------------
   function automatic void blank_pixels();
      for (int i = 0; i < PIXELS; i++) pixel_mem[i] = '0;
   endfunction

   function automatic alfe_pkg::rsp_type encode_step(input logic [1:0] op_bits,
                                                     input logic [39:0] d);
      alfe_pkg::rsp_type r;
      alfe_pkg::op_type  op;
      logic [7:0]  red, green, blue, light, led;
      int          offs;
      op    = alfe_pkg::op_type'(op_bits);
      red   = d[7:0];
      green = d[15:8];
      blue  = d[23:16];
      light = d[31:24];
      led   = d[39:32];
      r     = '0;
      case (op)
         alfe_pkg::OP_WRITE: begin
            // out-of-range coordinates drop the write
            if (!frame_active && light < LIGHTS && led < LEDS)
               pixel_mem[light * LEDS + led] = {green, red, blue};
         end
         alfe_pkg::OP_START: begin
            if (!frame_active) begin
               frame_active = 1'b1;
               frame_pos    = 0;
            end
         end
         alfe_pkg::OP_TICK: begin
            if (frame_active) begin
               r.byte_valid = 1'b1;
               r.busy_res   = 1'b1;
               if (frame_pos < PREAMBLE) begin
                  r.code_byte = alfe_pkg::CODE_RESET;
               end else begin
                  // pixel-major, MSB of green first
                  offs = frame_pos - PREAMBLE;
                  r.code_byte = pixel_mem[offs / alfe_pkg::BITS_PER_PIXEL]
                                         [alfe_pkg::BITS_PER_PIXEL - 1 -
                                          (offs % alfe_pkg::BITS_PER_PIXEL)] ?
                                alfe_pkg::CODE_ONE : alfe_pkg::CODE_ZERO;
               end
               frame_pos++;
               if (frame_pos >= FRAME_BYTES) begin
                  r.frame_last = 1'b1;
                  blank_pixels();
                  frame_active = 1'b0;
                  frame_pos    = 0;
               end
               return r;
            end
         end
         default: ;   // code three does nothing
      endcase
      r.busy_res = frame_active;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic add_cmd(input alfe_pkg::op_type op, input logic [7:0] red,
                          input logic [7:0] green,
                          input logic [7:0] blue, input logic [7:0] light,
                          input logic [7:0] led, input bit drain_first);
      led_cmd_type c;
      c.op          = op;
      c.red         = red;
      c.green       = green;
      c.blue        = blue;
      c.light       = light;
      c.led         = led;
      c.drain_first = drain_first;
      // a quiet stretch late in the random part
      c.calm        = (random_count >= 800 && random_count < 1100);
      cmd_backlog.push_back(c);
   endtask

   function automatic logic [7:0] rand_byte(input int lo, input int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   task automatic add_write(input int mode);
      logic [7:0] light, led;
      case (mode)
         0: begin   // in range
            light = rand_byte(0, LIGHTS - 1);
            led   = rand_byte(0, LEDS - 1);
         end
         1: begin   // out of range on one or both coordinates
            if ($urandom_range(0, 1)) begin
               light = rand_byte(LIGHTS, 255);
               led   = rand_byte(0, 255);
            end else begin
               light = rand_byte(0, 255);
               led   = rand_byte(LEDS, 255);
            end
         end
         default: begin
            light = rand_byte(0, 255);
            led   = rand_byte(0, 255);
         end
      endcase
      add_cmd(alfe_pkg::OP_WRITE, rand_byte(0, 255), rand_byte(0, 255),
              rand_byte(0, 255), light, led, 1'b0);
   endtask

   task automatic add_ticks(input int n);
      repeat (n) add_cmd(alfe_pkg::OP_TICK, rand_byte(0, 255), rand_byte(0, 255),
                         rand_byte(0, 255), rand_byte(0, 255),
                         rand_byte(0, 255), 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Driver: presents the backlog head, holds it until the transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      led_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_gap   <= 0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (idle_gap > 0) begin
            idle_gap   <= idle_gap - 1;
            req_tvalid <= 1'b0;
         end else if (cmd_backlog.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (cmd_backlog[0].drain_first &&
                      (!all_done || (req_tvalid && req_tready))) begin
            // wait for every outstanding result; a transfer at this edge
            // is not yet visible in all_done
            req_tvalid <= 1'b0;
         end else if (!cmd_backlog[0].calm && $urandom_range(0, 7) == 0) begin
            idle_gap   <= $urandom_range(1, 19) - 1;
            req_tvalid <= 1'b0;
         end else begin
            c = cmd_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {c.led, c.light, c.blue, c.green, c.red};
            req_tuser  <= c.op;
            calm_now   <= c.calm;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predicts on each command transfer, then checks each result
   // transfer against the oldest prediction. Both in one block so their
   // order within a step is fixed.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      alfe_pkg::rsp_type want;
      if (reset) begin
         blank_pixels();
         frame_active = 1'b1;   // power-up frame
         frame_pos    = 0;
         stall_left  <= 0;
         rsp_tready  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            code_forecast.push_back(encode_step(req_tuser, req_tdata));

         if (rsp_tvalid && rsp_tready) begin
            if (code_forecast.size() == 0) begin
               report_mismatch("unexpected result transfer", int'(rsp_tdata), 0);
            end else begin
               want = code_forecast.pop_front();
               if (rsp_tuser !== want.byte_valid)
                  report_mismatch("byte_valid", int'(rsp_tuser), int'(want.byte_valid));
               if (rsp_tdata[7:0] !== want.code_byte)
                  report_mismatch("code_byte", int'(rsp_tdata[7:0]), int'(want.code_byte));
               if (rsp_tdata[8] !== want.busy_res)
                  report_mismatch("busy_res", int'(rsp_tdata[8]), int'(want.busy_res));
               if (rsp_tdata[15:9] !== 7'd0)
                  report_mismatch("tdata fill", int'(rsp_tdata[15:9]), 0);
               if (rsp_tlast !== want.frame_last)
                  report_mismatch("frame_last", int'(rsp_tlast), int'(want.frame_last));
            end
         end

         // random stall bursts on the result side
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!calm_now && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(negedge clock) all_done <= (code_forecast.size() == 0);

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int n, k, ticks_left;
      random_count = 0;

      // Directed: ignored commands while the power-up frame is running
      add_cmd(alfe_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd0, 1'b0);
      add_cmd(alfe_pkg::OP_START, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0);
      add_cmd(alfe_pkg::OP_NOP,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      add_ticks(FRAME_BYTES);
      // idle: tick and code three report no byte
      add_cmd(alfe_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0);
      add_cmd(alfe_pkg::OP_NOP,  8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0);
      // corner pixels, then writes just past each coordinate limit
      add_cmd(alfe_pkg::OP_WRITE, 8'h00, 8'hFF, 8'hA5, 8'd0, 8'd0, 1'b0);
      add_cmd(alfe_pkg::OP_WRITE, 8'hFF, 8'h00, 8'h5A, 8'(LIGHTS - 1), 8'(LEDS - 1), 1'b0);
      add_cmd(alfe_pkg::OP_WRITE, 8'h01, 8'h80, 8'h7F, 8'(LIGHTS - 1), 8'd0, 1'b0);
      add_cmd(alfe_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'(LIGHTS), 8'd0, 1'b0);
      add_cmd(alfe_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'd0, 8'(LEDS), 1'b0);
      add_cmd(alfe_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      // start only after the block has drained
      add_cmd(alfe_pkg::OP_START, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b1);
      add_cmd(alfe_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd1, 1'b0);   // ignored, busy
      add_cmd(alfe_pkg::OP_START, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0);   // ignored, busy
      add_ticks(FRAME_BYTES);
      add_cmd(alfe_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0);

      // Random: idle phases of writes, then full frames with a little noise
      while (random_count < RANDOM_ITEMS) begin
         n = $urandom_range(1, 24);
         repeat (n) begin
            k = $urandom_range(0, 19);
            if (k < 14)       add_write(0);
            else if (k < 17)  add_write(1);
            else if (k == 17) add_ticks(1);
            else if (k == 18) add_cmd(alfe_pkg::OP_NOP, rand_byte(0, 255), rand_byte(0, 255),
                                      rand_byte(0, 255), rand_byte(0, 255),
                                      rand_byte(0, 255), 1'b0);
            else              add_write(2);
            random_count++;
         end
         add_cmd(alfe_pkg::OP_START, rand_byte(0, 255), rand_byte(0, 255),
                 rand_byte(0, 255), rand_byte(0, 255), rand_byte(0, 255),
                 $urandom_range(0, 3) == 0);
         random_count++;
         ticks_left = FRAME_BYTES;
         while (ticks_left > 0) begin
            if ($urandom_range(0, 15) == 0) begin
               // noise during the frame, all of it ignored
               k = $urandom_range(0, 2);
               if (k == 0)      add_write($urandom_range(0, 2));
               else if (k == 1) add_cmd(alfe_pkg::OP_START, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0,
                                        1'b0);
               else             add_cmd(alfe_pkg::OP_NOP, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0,
                                        1'b0);
            end else begin
               add_ticks(1);
               ticks_left--;
               random_count++;
            end
         end
      end
      // no idle at all in the tail of the run
      for (int i = cmd_backlog.size() - 250; i < cmd_backlog.size(); i++)
         cmd_backlog[i].calm = 1'b1;

      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || req_tvalid) @(negedge clock);
      while (code_forecast.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);   // catch any stray result

      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
